// ===== src/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg: shared types and constants of the filled circle span generator
// Holds the circle and span word layouts, the radius limit and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package fcsg_pkg;

	// Largest radius the block draws; larger requests saturate to it.
	localparam logic [5:0] MAX_RADIUS = 6'd63;

	// One circle request.
	typedef struct packed {
		logic [9:0]  center_x;
		logic [9:0]  center_y;
		logic [5:0]  radius;
		logic [23:0] fill_color;
	} circle_word_t;

	// One mirrored pair of horizontal spans.
	typedef struct packed {
		logic [5:0]         row_offset;
		logic signed [11:0] span_left_x;
		logic signed [11:0] span_right_x;
		logic signed [11:0] lower_row_y;
		logic signed [11:0] upper_row_y;
		logic [23:0]        span_color;
		logic               last_row;
	} span_word_t;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RSQ  = 3'b010,
		ST_TEST = 3'b100
	} seq_state_t;

	// Operands of the shared square-and-compare unit.
	typedef struct packed {
		logic [5:0]  operand;
		logic [11:0] addend;
		logic [11:0] threshold;
	} sqr_req_t;

	// Results of the shared square-and-compare unit.
	typedef struct packed {
		logic [11:0] square;
		logic        at_least;
	} sqr_rsp_t;

endpackage

// ===== src/filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator: filled circle scanline span generator
// Turns one circle request into one span word per row offset, from the
// center row out to the radius, each holding a mirrored pair of spans.
// ----------------------------------------------------------------------------
// Usage:
// A circle word is taken when circle_valid is high and circle_stall is low.
// circle_stall stays high from the cycle after a circle is taken until its
// last span word (last_row set) has been loaded into the output register.
// For radius r the block emits r+1 span words, one per row offset.
// Before each row the half-width shrinks one step at a time until it lies
// inside the circle; it shrinks exactly r times per circle. The radius is
// squared once, before the first row.
// Span words sit in an output register; when span_stall is high the word
// holds and the sequencer waits on the row it has ready.
// Reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module filled_circle_span_generator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   circle_valid,
	output logic                   circle_stall,
	input  fcsg_pkg::circle_word_t circle,
	output logic                   span_valid,
	input  logic                   span_stall,
	output fcsg_pkg::span_word_t   span
);

	logic                 seq_idle;
	logic                 seq_emit;
	logic                 out_free;
	fcsg_pkg::span_word_t seq_word;
	logic                 span_valid_q;
	fcsg_pkg::span_word_t span_q;

	assign circle_stall = !seq_idle;
	assign out_free     = !span_valid_q || !span_stall;

	fcsg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (circle_valid),
		.circle   (circle),
		.out_free (out_free),
		.emit     (seq_emit),
		.emit_word(seq_word),
		.idle     (seq_idle)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (out_free) begin
			span_valid_q <= seq_emit;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (seq_emit) begin
			span_q <= seq_word;
		end
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

`ifndef SYNTHESIS
	// A taken circle makes the block busy on the next cycle.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		circle_valid && !circle_stall |=> circle_stall)
		else $error("circle accepted but block not busy");

	// A word that is not the last of its circle leaves the block busy.
	a_busy_mid_circle: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span.last_row |-> circle_stall)
		else $error("block idle while a circle is unfinished");

	// Spans never run backward.
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid |-> span.span_right_x >= span.span_left_x)
		else $error("span right end before left end");

	// The two rows sit symmetrically about the center row.
	a_row_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid |-> (12'(span.lower_row_y - span.upper_row_y)
			== {5'd0, span.row_offset, 1'b0}))
		else $error("span rows not mirrored");
`endif

endmodule

// ===== src/fcsg_sqr_unit.sv =====
// ----------------------------------------------------------------------------
// fcsg_sqr_unit: shared square, add and compare unit
// Squares a 6-bit operand, adds an offset and tests the sum against a
// threshold. Used for the radius square and every half-width test.
// ----------------------------------------------------------------------------
module fcsg_sqr_unit (
	input  fcsg_pkg::sqr_req_t req,
	output fcsg_pkg::sqr_rsp_t rsp
);

	logic [11:0] square;
	logic [12:0] sum;

	// A 6x6 square always fits in 12 bits; the sum gets one more bit.
	assign square = 12'(req.operand) * 12'(req.operand);
	assign sum    = {1'b0, square} + {1'b0, req.addend};

	assign rsp.square   = square;
	assign rsp.at_least = (sum >= {1'b0, req.threshold});

endmodule

// ===== src/fcsg_seq.sv =====
// ----------------------------------------------------------------------------
// fcsg_seq: row sequencer of the filled circle span generator
// Holds the circle, steps the row offset and shrinks the half-width one
// step per cycle through the shared square unit, then hands out one span
// word per row.
// ----------------------------------------------------------------------------
module fcsg_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  fcsg_pkg::circle_word_t  circle,
	input  logic                    out_free,
	output logic                    emit,
	output fcsg_pkg::span_word_t    emit_word,
	output logic                    idle
);

	fcsg_pkg::seq_state_t state_q;
	logic [9:0]  cx_q;
	logic [9:0]  cy_q;
	logic [5:0]  radius_q;
	logic [23:0] color_q;
	logic [11:0] rsq_q;
	logic [11:0] isq_q;
	logic [5:0]  row_q;
	logic [5:0]  half_q;

	fcsg_pkg::sqr_req_t req;
	fcsg_pkg::sqr_rsp_t rsp;
	logic [5:0] radius_sat;
	logic       shrink;
	logic       is_last;

	// Clamp the requested radius to the supported limit.
	assign radius_sat = (circle.radius > fcsg_pkg::MAX_RADIUS) ?
		fcsg_pkg::MAX_RADIUS : circle.radius;

	// The shared unit squares the radius first, then the half-width.
	always_comb begin
		req.operand   = (state_q == fcsg_pkg::ST_RSQ) ? radius_q : half_q;
		req.addend    = (state_q == fcsg_pkg::ST_RSQ) ? 12'd0 : isq_q;
		req.threshold = rsq_q;
	end

	fcsg_sqr_unit u_sqr (
		.req(req),
		.rsp(rsp)
	);

	// Shrink while the half-width is nonzero and still reaches the rim.
	assign shrink  = (half_q != 6'd0) && rsp.at_least;
	assign is_last = (row_q == radius_q);
	assign emit    = (state_q == fcsg_pkg::ST_TEST) && !shrink && out_free;
	assign idle    = (state_q == fcsg_pkg::ST_IDLE);

	// Span word for the current row.
	always_comb begin
		emit_word.row_offset   = row_q;
		emit_word.span_left_x  = {2'b00, cx_q} - {6'd0, half_q};
		emit_word.span_right_x = {2'b00, cx_q} + {6'd0, half_q};
		emit_word.lower_row_y  = {2'b00, cy_q} + {6'd0, row_q};
		emit_word.upper_row_y  = {2'b00, cy_q} - {6'd0, row_q};
		emit_word.span_color   = color_q;
		emit_word.last_row     = is_last;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcsg_pkg::ST_IDLE;
		end else begin
			case (state_q)
				fcsg_pkg::ST_IDLE: begin
					if (take) begin
						state_q <= fcsg_pkg::ST_RSQ;
					end
				end
				fcsg_pkg::ST_RSQ: begin
					state_q <= fcsg_pkg::ST_TEST;
				end
				fcsg_pkg::ST_TEST: begin
					if (emit && is_last) begin
						state_q <= fcsg_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fcsg_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Circle registers, radius square, row offset and half-width.
	always_ff @(posedge clk) begin
		if (idle && take) begin
			cx_q     <= circle.center_x;
			cy_q     <= circle.center_y;
			radius_q <= radius_sat;
			color_q  <= circle.fill_color;
			half_q   <= radius_sat;
			row_q    <= 6'd0;
			isq_q    <= 12'd0;
		end
		if (state_q == fcsg_pkg::ST_RSQ) begin
			rsq_q <= rsp.square;
		end
		if (state_q == fcsg_pkg::ST_TEST) begin
			if (shrink) begin
				half_q <= half_q - 6'd1;
			end else if (emit && !is_last) begin
				// Next square is the current one plus 2i+1.
				row_q <= row_q + 6'd1;
				isq_q <= isq_q + {5'd0, row_q, 1'b1};
			end
		end
	end

endmodule

// ===== tb/filled_circle_span_generator_tb.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator_tb: self-checking bench for the span generator
// Sends directed and random circle words, predicts every span word of each
// circle in a scoreboard, and checks the span words in order. Random gaps
// on the circle side, random stalls on the span side and one long stall
// exercise the handshakes.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_CIRCLES = 220;
	localparam int IDLE_LIMIT     = 2000;
	localparam int DRAIN_CYCLES   = 150;
	localparam int PRESSURE_AFTER = 60;
	localparam int PRESSURE_HOLD  = 400;

	// Predicts the span words of each accepted circle and checks them in order.
	class span_scoreboard;
		fcsg_pkg::span_word_t expected_spans[$];
		int mismatches;
		int circles_noted;
		int spans_checked;

		function new();
			mismatches = 0;
			circles_noted = 0;
			spans_checked = 0;
		endfunction

		// Walks the rows from the center outward, shrinking the half-width
		// until it lies inside the circle before each row is produced.
		function void note_circle(fcsg_pkg::circle_word_t c);
			fcsg_pkg::span_word_t s;
			int r;
			int rsq;
			int h;
			int cx;
			int cy;
			r = c.radius;
			if (r > fcsg_pkg::MAX_RADIUS)
				r = fcsg_pkg::MAX_RADIUS;
			rsq = (r * r) & 'hFFF;
			h = r;
			cx = c.center_x;
			cy = c.center_y;
			for (int i = 0; i <= r; i++) begin
				while (h > 0 && h * h + i * i >= rsq)
					h--;
				s.row_offset   = 6'(i);
				s.span_left_x  = 12'(cx - h);
				s.span_right_x = 12'(cx + h);
				s.lower_row_y  = 12'(cy + i);
				s.upper_row_y  = 12'(cy - i);
				s.span_color   = c.fill_color;
				s.last_row     = (i == r);
				expected_spans.push_back(s);
			end
			circles_noted++;
		endfunction

		function void compare_field(string field, logic signed [31:0] want,
				logic signed [31:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_span(fcsg_pkg::span_word_t got);
			fcsg_pkg::span_word_t want;
			if (expected_spans.size() == 0) begin
				mismatches++;
				$display("%0t: span word %h arrived with none expected", $time, got);
				return;
			end
			want = expected_spans.pop_front();
			compare_field("row_offset", want.row_offset, got.row_offset);
			compare_field("span_left_x", want.span_left_x, got.span_left_x);
			compare_field("span_right_x", want.span_right_x, got.span_right_x);
			compare_field("lower_row_y", want.lower_row_y, got.lower_row_y);
			compare_field("upper_row_y", want.upper_row_y, got.upper_row_y);
			compare_field("span_color", want.span_color, got.span_color);
			compare_field("last_row", want.last_row, got.last_row);
			spans_checked++;
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   circle_valid;
	logic                   circle_stall;
	fcsg_pkg::circle_word_t circle;
	logic                   span_valid;
	logic                   span_stall;
	fcsg_pkg::span_word_t   span;

	span_scoreboard sb;
	int idle_cycles;

	filled_circle_span_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.circle_valid (circle_valid),
		.circle_stall (circle_stall),
		.circle       (circle),
		.span_valid   (span_valid),
		.span_stall   (span_stall),
		.span         (span)
	);

	// 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offers one circle word and holds it until the block takes it.
	task automatic send_circle(input fcsg_pkg::circle_word_t c);
		circle <= c;
		circle_valid <= 1'b1;
		do
			@(posedge clk);
		while (circle_stall);
		sb.note_circle(c);
	endtask

	// Drops valid for a random gap, usually short and now and then long.
	task automatic pause_sender();
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			gap = 0;
		else if (pick < 88)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(5, 80);
		if (gap > 0) begin
			circle_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random circle word; most radii are small, a few near the limit, and
	// some centers sit near the raster edges so the spans leave the range.
	function automatic fcsg_pkg::circle_word_t random_circle();
		fcsg_pkg::circle_word_t c;
		int pick;
		c.center_x   = 10'($urandom_range(0, 1023));
		c.center_y   = 10'($urandom_range(0, 1023));
		c.fill_color = 24'($urandom());
		if ($urandom_range(0, 99) < 15)
			c.center_x = $urandom_range(0, 1) ? 10'($urandom_range(0, 40))
				: 10'($urandom_range(983, 1023));
		if ($urandom_range(0, 99) < 15)
			c.center_y = $urandom_range(0, 1) ? 10'($urandom_range(0, 40))
				: 10'($urandom_range(983, 1023));
		pick = $urandom_range(0, 99);
		if (pick < 60)
			c.radius = 6'($urandom_range(0, 12));
		else if (pick < 88)
			c.radius = 6'($urandom_range(0, 63));
		else
			c.radius = 6'($urandom_range(50, 63));
		return c;
	endfunction

	// Span side: checks each accepted word and drives random stall runs,
	// with one long hold while the sender keeps offering circles.
	initial begin : span_sink
		int run_left;
		int hold_left;
		bit stall_run;
		bit pressure_done;
		run_left = 0;
		hold_left = 0;
		stall_run = 1'b0;
		pressure_done = 1'b0;
		span_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && span_valid && !span_stall)
				sb.check_span(span);
			if (!pressure_done && sb.spans_checked >= PRESSURE_AFTER) begin
				pressure_done = 1'b1;
				hold_left = PRESSURE_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				span_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stall_run = ($urandom_range(0, 99) < 35);
					if (stall_run)
						run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
							: $urandom_range(4, 40);
					else
						run_left = $urandom_range(1, 30);
				end
				run_left--;
				span_stall <= stall_run;
			end
		end
	end

	// Watchdog: ends the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((circle_valid && !circle_stall) || (span_valid && !span_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
				$display("filled_circle_span_generator: mismatch");
				$finish;
			end
		end
	end

	// Stimulus: reset, directed circles, random circles, then drain.
	initial begin : stimulus
		fcsg_pkg::circle_word_t directed_circles[$];
		sb = new();
		idle_cycles = 0;
		arst_n <= 1'b0;
		circle_valid <= 1'b0;
		circle <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero radius, the smallest radii, the largest radius away from the edges
		// and at two corners, and alternating bit patterns in every field.
		directed_circles.push_back('{10'd512, 10'd512, 6'd0, 24'h000000});
		directed_circles.push_back('{10'd512, 10'd512, 6'd1, 24'hFFFFFF});
		directed_circles.push_back('{10'd512, 10'd512, 6'd2, 24'h123456});
		directed_circles.push_back('{10'd300, 10'd700, 6'd63, 24'hAAAAAA});
		directed_circles.push_back('{10'd0, 10'd0, 6'd63, 24'h555555});
		directed_circles.push_back('{10'd1023, 10'd1023, 6'd63, 24'hFFFFFF});
		directed_circles.push_back('{10'd0, 10'd1023, 6'd5, 24'h000000});
		directed_circles.push_back('{10'd1023, 10'd0, 6'd5, 24'h00FF00});
		directed_circles.push_back('{10'h2AA, 10'h155, 6'h2A, 24'h0F0F0F});
		directed_circles.push_back('{10'h155, 10'h2AA, 6'h15, 24'hF0F0F0});
		directed_circles.push_back('{10'd0, 10'd0, 6'd0, 24'hFFFFFF});
		directed_circles.push_back('{10'd1023, 10'd1023, 6'd0, 24'h000001});
		directed_circles.push_back('{10'd100, 10'd900, 6'd3, 24'h800000});
		directed_circles.push_back('{10'd900, 10'd100, 6'd4, 24'h7FFFFF});
		directed_circles.push_back('{10'd64, 10'd64, 6'd7, 24'hC3C3C3});
		directed_circles.push_back('{10'd5, 10'd1018, 6'd10, 24'h3C3C3C});
		foreach (directed_circles[k]) begin
			send_circle(directed_circles[k]);
			pause_sender();
		end

		for (int n = 0; n < RANDOM_CIRCLES; n++) begin
			send_circle(random_circle());
			pause_sender();
		end
		circle_valid <= 1'b0;

		while (sb.expected_spans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.expected_spans.size() != 0) begin
			sb.mismatches++;
			$display("%0t: %0d span words never arrived", $time, sb.expected_spans.size());
		end
		$display("Checked %0d span words from %0d circles, radii 0 to 63,", sb.spans_checked,
			sb.circles_noted);
		$display("including edge centers, random gaps and stalls, and one long output hold.");
		if (sb.mismatches == 0) begin
			$display("filled_circle_span_generator: match");
		end else begin
			$display("filled_circle_span_generator: mismatch");
		end
		$finish;
	end

endmodule
